// ----- rtl/core/mcat_pkg.sv -----
// Package for the timer bank core: opcodes, kinds, entry record and widths.
// No dependencies.
`default_nettype none
package mcat_pkg;
    localparam int NUM_TIMERS_DEFAULT = 8;
    localparam int MAX_FIRES = 8;
    localparam logic [31:0] SECS_PER_DAY = 32'd86400;

    typedef enum logic [3:0] {
        OP_TICK_MS = 4'd0, OP_TICK_SEC = 4'd1, OP_PROCESS = 4'd2, OP_RENEW = 4'd3,
        OP_START = 4'd4, OP_STOP = 4'd5, OP_SET_PERIOD = 4'd6, OP_SET_KIND = 4'd7,
        OP_SHIFT = 4'd8, OP_QUERY = 4'd9
    } op_t;

    localparam logic [1:0] KIND_INTERVAL = 2'd0;
    localparam logic [1:0] KIND_DAILY = 2'd1;
    localparam logic [1:0] KIND_MS = 2'd2;

    typedef struct packed {
        logic        en;
        logic        rdy;
        logic [1:0]  kind;
        logic [15:0] period;
        logic [15:0] ms_count;
        logic [31:0] due;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MOD, ST_DAY, ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/core/mcat_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module mcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/mcat_daymod.sv -----
// Registered midnight (now minus now mod 86400) by reciprocal multiply with correction.
// Depends on mcat_pkg.
`default_nettype none
module mcat_daymod (
    input  wire logic        aclk,
    input  wire logic [31:0] now,
    output logic      [31:0] midnight_reg
);
    // q ~ now*2^-16 /1.318359375 ; floor(now/86400) via (now>>7)/675
    // two stages: quotient estimate, then multiply back and correct
    logic [24:0] hi;
    logic [49:0] prod;
    logic [16:0] q_reg, q_next;
    logic [33:0] base;
    logic [31:0] rem;
    logic [31:0] mid_next;
    always_comb begin
        hi = now[31:7];
        prod = {25'd0, hi} * 50'd24855; // 2^24/675 rounded down
        q_next = prod[40:24];
        base = {17'd0, q_reg} * 34'd86400;
        rem = now - base[31:0];
        mid_next = base[31:0];
        if (rem >= mcat_pkg::SECS_PER_DAY) begin
            mid_next = mid_next + mcat_pkg::SECS_PER_DAY;
            rem = rem - mcat_pkg::SECS_PER_DAY;
        end
        if (rem >= mcat_pkg::SECS_PER_DAY) begin
            mid_next = mid_next + mcat_pkg::SECS_PER_DAY;
        end
    end
    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        midnight_reg <= mid_next;
    end
endmodule
`default_nettype wire

// ----- rtl/core/multi_channel_alarm_timer_bank_core.sv -----
// Top level of the timer bank: sequencer over the entry RAM.
// Depends on mcat_pkg, mcat_ram, mcat_daymod.
//
// Usage: requests enter on s_valid/s_ready with op, index, period, kind, now and
// shift fields. Results leave on m_valid/m_ready, one per fired timer for
// process and one for query, last marking the final one. Other ops give none.
// Timer state is in one RAM of NUM_TIMERS records (depth rounded up to a
// power of two). Bank-wide ops walk every timer in three steps (read, modify,
// write back with rearm), then close through a last read and the output
// state; s_ready is high only in idle, so a new request waits for the end.
// Single-timer ops do these steps on one record; a query result is loaded in
// the output state. A firing is held one deep until the next firing or the
// end of the walk, so last can be set on it. Throughput is set by the one RAM
// port doing read-modify-write per timer. After reset, a clearing pass writes
// each used record to its reset value; s_ready is low meanwhile. A receiver
// stall halts the walk, the result held in the output register until taken.
`default_nettype none
module multi_channel_alarm_timer_bank_core #(
    parameter int NUM_TIMERS = mcat_pkg::NUM_TIMERS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_op,
    input  wire logic [7:0]  s_timer_index,
    input  wire logic [15:0] s_period_value,
    input  wire logic [1:0]  s_alarm_kind,
    input  wire logic [31:0] s_now_seconds,
    input  wire logic signed [31:0] s_shift_delta,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_fired_valid,
    output logic [2:0]       m_fired_index,
    output logic             m_enabled_status,
    output logic [31:0]      m_next_time,
    output logic             m_last
);
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    mcat_pkg::state_t state_reg, state_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          clr_reg, clr_next;
    logic [3:0]    op_reg;
    logic [7:0]    idx_reg;
    logic [15:0]   per_reg;
    logic [1:0]    kind_reg;
    logic [31:0]   now_reg, delta_reg;
    logic [3:0]    nfire_reg, nfire_next;
    mcat_pkg::entry_t mod_reg, mod_next, rd;
    logic          pend_reg, pend_next;   // result held for emit
    logic [2:0]    pidx_reg, pidx_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [mcat_pkg::ENTRY_W-1:0] wdata, rdata;
    logic [31:0] midnight;

    mcat_ram #(.WIDTH(mcat_pkg::ENTRY_W), .DEPTH(1 << AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    mcat_daymod u_day (.aclk(aclk), .now(now_reg), .midnight_reg(midnight));

    assign rd = mcat_pkg::entry_t'(rdata);
    wire single = (op_reg == mcat_pkg::OP_START) || (op_reg == mcat_pkg::OP_STOP)
        || (op_reg == mcat_pkg::OP_SET_PERIOD) || (op_reg == mcat_pkg::OP_SET_KIND)
        || (op_reg == mcat_pkg::OP_QUERY);
    wire [AW-1:0] cur = single ? idx_reg[AW-1:0] : ptr_reg[AW-1:0];

    logic [32:0] today;
    always_comb begin
        today = {1'b0, midnight} + {17'd0, mod_reg.period};
    end

    // output register
    logic ov_reg, ofv_reg, oen_reg, olast_reg;
    logic ov_next, ofv_next, oen_next, olast_next;
    logic [2:0] ofi_reg, ofi_next;
    logic [31:0] ont_reg, ont_next;
    logic load_out, flush_out;
    logic lo_fv, lo_en, lo_last;
    logic [2:0] lo_fi;
    logic [31:0] lo_nt;
    wire out_free = !ov_reg || m_ready;

    // process results are held one deep so last can be set on the final one
    logic hv_reg, hv_next;
    logic [2:0] hi_reg, hi_next;

    always_comb begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        clr_next = clr_reg;
        nfire_next = nfire_reg;
        mod_next = mod_reg;
        pend_next = pend_reg;
        pidx_next = pidx_reg;
        we = 1'b0;
        waddr = cur;
        wdata = mod_reg;
        raddr = cur;
        s_ready = 1'b0;
        load_out = 1'b0;
        flush_out = 1'b0;
        lo_fv = 1'b0; lo_fi = '0; lo_en = 1'b0; lo_nt = '0; lo_last = 1'b0;
        if (clr_reg) begin
            we = 1'b1;
            waddr = ptr_reg[AW-1:0];
            wdata = '0;
            ptr_next = ptr_reg + CW'(1);
            if (ptr_reg == CW'(NUM_TIMERS - 1)) begin
                clr_next = 1'b0;
                ptr_next = '0;
            end
        end else begin
            unique case (state_reg)
                mcat_pkg::ST_IDLE: begin
                    s_ready = 1'b1;
                    ptr_next = '0;
                    nfire_next = '0;
                    pend_next = 1'b0;
                    if (s_valid) begin
                        state_next = mcat_pkg::ST_READ;
                    end
                end
                mcat_pkg::ST_READ: begin
                    state_next = mcat_pkg::ST_MOD;
                    if (single && idx_reg >= 8'(NUM_TIMERS)) begin
                        state_next = (op_reg == mcat_pkg::OP_QUERY)
                            ? mcat_pkg::ST_OUT : mcat_pkg::ST_IDLE;
                        mod_next = '0;
                    end else if (!single && (op_reg > mcat_pkg::OP_SHIFT
                            || ptr_reg == CW'(NUM_TIMERS))) begin
                        state_next = mcat_pkg::ST_OUT;
                    end
                end
                mcat_pkg::ST_MOD: begin
                    mod_next = rd;
                    state_next = mcat_pkg::ST_DAY;
                    case (op_reg)
                        mcat_pkg::OP_TICK_MS:
                            if (rd.en && rd.kind == mcat_pkg::KIND_MS) begin
                                if (rd.ms_count < rd.period) begin
                                    mod_next.ms_count = rd.ms_count + 16'd1;
                                end else begin
                                    mod_next.rdy = 1'b1;
                                end
                            end
                        mcat_pkg::OP_TICK_SEC:
                            if (rd.en && rd.kind != mcat_pkg::KIND_MS && !rd.rdy
                                    && now_reg >= rd.due) begin
                                mod_next.rdy = 1'b1;
                            end
                        mcat_pkg::OP_PROCESS:
                            if (rd.en && rd.rdy && nfire_reg < 4'(mcat_pkg::MAX_FIRES)) begin
                                mod_next.rdy = 1'b0;
                                pend_next = 1'b1;
                                pidx_next = 3'(ptr_reg);
                                nfire_next = nfire_reg + 4'd1;
                            end
                        mcat_pkg::OP_START: mod_next.en = 1'b1;
                        mcat_pkg::OP_STOP: mod_next.en = 1'b0;
                        mcat_pkg::OP_SET_PERIOD: mod_next.period = per_reg;
                        mcat_pkg::OP_SET_KIND:
                            if (kind_reg <= mcat_pkg::KIND_MS) begin
                                mod_next.kind = kind_reg;
                            end
                        mcat_pkg::OP_SHIFT:
                            if (rd.en) begin
                                mod_next.due = rd.due + delta_reg;
                            end
                        default: ;
                    endcase
                    if (op_reg == mcat_pkg::OP_QUERY) begin
                        state_next = mcat_pkg::ST_OUT;
                    end
                end
                mcat_pkg::ST_DAY: begin
                    // rearm then write back
                    if ((op_reg == mcat_pkg::OP_PROCESS && pend_reg)
                            || (op_reg == mcat_pkg::OP_RENEW && mod_reg.en)
                            || op_reg == mcat_pkg::OP_START) begin
                        case (mod_reg.kind)
                            mcat_pkg::KIND_DAILY:
                                wdata = mcat_pkg::entry_t'({mod_reg.en, mod_reg.rdy,
                                    mod_reg.kind, mod_reg.period, mod_reg.ms_count,
                                    (today <= {1'b0, now_reg})
                                        ? today[31:0] + mcat_pkg::SECS_PER_DAY
                                        : today[31:0]});
                            mcat_pkg::KIND_INTERVAL:
                                wdata = mcat_pkg::entry_t'({mod_reg.en, mod_reg.rdy,
                                    mod_reg.kind, mod_reg.period, mod_reg.ms_count,
                                    now_reg + {16'd0, mod_reg.period}});
                            mcat_pkg::KIND_MS:
                                wdata = mcat_pkg::entry_t'({mod_reg.en, mod_reg.rdy,
                                    mod_reg.kind, mod_reg.period, 16'd0, mod_reg.due});
                            default: ;
                        endcase
                    end
                    if (!pend_reg || out_free) begin
                        we = 1'b1;
                        if (pend_reg) begin
                            load_out = 1'b1;
                            lo_fv = 1'b1;
                            lo_fi = pidx_reg;
                            pend_next = 1'b0;
                        end
                        if (single) begin
                            state_next = mcat_pkg::ST_IDLE;
                        end else begin
                            ptr_next = ptr_reg + CW'(1);
                            state_next = mcat_pkg::ST_READ;
                        end
                    end
                end
                mcat_pkg::ST_OUT: begin
                    // final marker: query result, or last flag on last firing
                    if (op_reg == mcat_pkg::OP_QUERY) begin
                        if (out_free) begin
                            load_out = 1'b1;
                            lo_en = mod_reg.en;
                            lo_nt = mod_reg.en ? mod_reg.due : 32'd0;
                            lo_last = 1'b1;
                            state_next = mcat_pkg::ST_IDLE;
                        end
                    end else if (!hv_reg || out_free) begin
                        flush_out = hv_reg;
                        state_next = mcat_pkg::ST_IDLE;
                    end
                end
                default: state_next = mcat_pkg::ST_IDLE;
            endcase
        end
    end

    always_comb begin
        hv_next = hv_reg;
        hi_next = hi_reg;
        ov_next = ov_reg && !m_ready;
        ofv_next = ofv_reg;
        ofi_next = ofi_reg;
        oen_next = oen_reg;
        ont_next = ont_reg;
        olast_next = olast_reg;
        if (load_out && lo_fv) begin
            // a firing enters the holding slot; the previous one goes out
            hv_next = 1'b1;
            hi_next = lo_fi;
            if (hv_reg) begin
                ov_next = 1'b1;
                ofv_next = 1'b1; ofi_next = hi_reg; oen_next = 1'b0;
                ont_next = '0; olast_next = 1'b0;
            end
        end else if (load_out) begin
            ov_next = 1'b1;
            ofv_next = 1'b0; ofi_next = '0; oen_next = lo_en;
            ont_next = lo_nt; olast_next = lo_last;
        end else if (flush_out) begin
            hv_next = 1'b0;
            ov_next = 1'b1;
            ofv_next = 1'b1; ofi_next = hi_reg; oen_next = 1'b0;
            ont_next = '0; olast_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcat_pkg::ST_IDLE;
            clr_reg <= 1'b1;
            ptr_reg <= '0;
            nfire_reg <= '0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            hv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            ptr_reg <= ptr_next;
            nfire_reg <= nfire_next;
            pend_reg <= pend_next;
            hv_reg <= hv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        mod_reg <= mod_next;
        pidx_reg <= pidx_next;
        ofv_reg <= ofv_next;
        ofi_reg <= ofi_next;
        oen_reg <= oen_next;
        ont_reg <= ont_next;
        olast_reg <= olast_next;
        if (s_valid && s_ready) begin
            op_reg <= s_op;
            idx_reg <= s_timer_index;
            per_reg <= s_period_value;
            kind_reg <= s_alarm_kind;
            now_reg <= s_now_seconds;
            delta_reg <= s_shift_delta;
        end
    end

    assign m_valid = ov_reg;
    assign m_fired_valid = ofv_reg;
    assign m_fired_index = ofi_reg;
    assign m_enabled_status = oen_reg;
    assign m_next_time = ont_reg;
    assign m_last = olast_reg;
endmodule
`default_nettype wire

// ----- rtl/core/mcat_checker.sv -----
// Port-level checks for the timer bank core, bound to the top level.
// Depends on multi_channel_alarm_timer_bank_core ports only.
`default_nettype none
module mcat_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_fired_valid,
    input wire logic        m_enabled_status,
    input wire logic [31:0] m_next_time,
    input wire logic        m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_time) && $stable(m_last))
        else $error("result changed while stalled");
    a_fire_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fired_valid |-> !m_enabled_status && m_next_time == 32'd0)
        else $error("firing result carries query fields");
    a_query_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fired_valid && !m_enabled_status |-> m_next_time == 32'd0)
        else $error("disabled query with nonzero time");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted on consecutive cycles");
endmodule

bind multi_channel_alarm_timer_bank_core mcat_checker u_mcat_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_fired_valid(m_fired_valid),
    .m_enabled_status(m_enabled_status), .m_next_time(m_next_time), .m_last(m_last)
);
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for multi_channel_alarm_timer_bank_core: directed and random requests,
// results checked against an in-bench model of the timer bank.
// Depends on mcat_pkg and the core RTL.
`timescale 1ns / 100ps
module tb;
    import mcat_pkg::*;

    localparam int NT = 8;
    localparam int LIMIT = 400000;

    typedef struct {
        logic        fv;
        logic [2:0]  fi;
        logic        en;
        logic [31:0] nt;
        logic        lst;
    } timer_result_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    logic [3:0] s_op = 0;
    logic [7:0] s_timer_index = 0;
    logic [15:0] s_period_value = 0;
    logic [1:0] s_alarm_kind = 0;
    logic [31:0] s_now_seconds = 0;
    logic signed [31:0] s_shift_delta = 0;
    logic m_fired_valid, m_enabled_status, m_last;
    logic [2:0] m_fired_index;
    logic [31:0] m_next_time;

    multi_channel_alarm_timer_bank_core #(.NUM_TIMERS(NT)) dut (.*);

    // model state
    logic        en_q[NT], rdy_q[NT];
    logic [1:0]  kind_q[NT];
    logic [15:0] per_q[NT], ms_q[NT];
    logic [31:0] due_q[NT];
    timer_result_t pending_results[$];

    int errors = 0, cycles = 0, sent = 0, fires_seen = 0, queries_seen = 0;
    logic hold_off = 0;
    logic [31:0] clock_now = 32'd1000;

    initial forever #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("multi_channel_alarm_timer_bank_core verification failed");
            $finish;
        end
    end

    function automatic void rearm_timer(int t, logic [31:0] now);
        logic [32:0] today;
        logic [31:0] midnight;
        midnight = now - (now % SECS_PER_DAY);
        if (kind_q[t] == KIND_DAILY) begin
            today = {1'b0, midnight} + per_q[t];
            due_q[t] = (today <= {1'b0, now}) ? today[31:0] + SECS_PER_DAY : today[31:0];
        end else if (kind_q[t] == KIND_INTERVAL) begin
            due_q[t] = now + per_q[t];
        end else if (kind_q[t] == KIND_MS) begin
            ms_q[t] = 0;
        end
    endfunction

    function automatic void predict_timer_bank(logic [3:0] op, logic [7:0] idx,
            logic [15:0] per, logic [1:0] kind, logic [31:0] now, logic [31:0] delta);
        timer_result_t r;
        int n;
        logic inr;
        inr = idx < NT;
        n = 0;
        case (op)
            OP_TICK_MS: for (int t = 0; t < NT; t++)
                if (en_q[t] && kind_q[t] == KIND_MS) begin
                    if (ms_q[t] < per_q[t]) ms_q[t]++;
                    else rdy_q[t] = 1;
                end
            OP_TICK_SEC: for (int t = 0; t < NT; t++)
                if (en_q[t] && kind_q[t] != KIND_MS && !rdy_q[t] && now >= due_q[t])
                    rdy_q[t] = 1;
            OP_PROCESS: for (int t = 0; t < NT && n < MAX_FIRES; t++)
                if (en_q[t] && rdy_q[t]) begin
                    rdy_q[t] = 0;
                    r = '{1'b1, t[2:0], 1'b0, 32'd0, 1'b0};
                    pending_results.push_back(r);
                    n++;
                    rearm_timer(t, now);
                end
            OP_RENEW: for (int t = 0; t < NT; t++) if (en_q[t]) rearm_timer(t, now);
            OP_START: if (inr) begin
                en_q[idx] = 1;
                rearm_timer(idx, now);
            end
            OP_STOP: if (inr) en_q[idx] = 0;
            OP_SET_PERIOD: if (inr) per_q[idx] = per;
            OP_SET_KIND: if (inr && kind <= KIND_MS) kind_q[idx] = kind;
            OP_SHIFT: for (int t = 0; t < NT; t++) if (en_q[t]) due_q[t] += delta;
            OP_QUERY: begin
                if (inr && en_q[idx]) r = '{1'b0, 3'd0, 1'b1, due_q[idx], 1'b0};
                else r = '{1'b0, 3'd0, 1'b0, 32'd0, 1'b0};
                pending_results.push_back(r);
                n = 1;
            end
            default: ;
        endcase
        if (n > 0) pending_results[$].lst = 1;
    endfunction

    // result checker
    always @(posedge aclk) begin
        timer_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result fired_index=%0d", m_fired_index);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_fired_valid) fires_seen++; else queries_seen++;
                if (m_fired_valid !== e.fv) begin
                    $error("fired_valid exp %0h got %0h", e.fv, m_fired_valid); errors++;
                end
                if (m_fired_index !== e.fi) begin
                    $error("fired_index exp %0h got %0h", e.fi, m_fired_index); errors++;
                end
                if (m_enabled_status !== e.en) begin
                    $error("enabled_status exp %0h got %0h", e.en, m_enabled_status);
                    errors++;
                end
                if (m_next_time !== e.nt) begin
                    $error("next_time exp %0h got %0h", e.nt, m_next_time); errors++;
                end
                if (m_last !== e.lst) begin
                    $error("last exp %0h got %0h", e.lst, m_last); errors++;
                end
            end
        end
    end

    // receiver stall pattern
    initial begin
        int k;
        forever begin
            @(negedge aclk);
            k++;
            if (hold_off) m_ready <= 0;
            else if (k % 64 < 20) m_ready <= 1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    int burst_left = 0;

    task automatic send_request(logic [3:0] op, logic [7:0] idx, logic [15:0] per,
            logic [1:0] kind, logic [31:0] now, logic [31:0] delta);
        logic acc;
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1;
        s_op <= op;
        s_timer_index <= idx;
        s_period_value <= per;
        s_alarm_kind <= kind;
        s_now_seconds <= now;
        s_shift_delta <= delta;
        acc = 1'b0;
        while (!acc) begin
            acc = s_ready;
            @(posedge aclk);
            if (!acc) @(negedge aclk);
        end
        predict_timer_bank(op, idx, per, kind, now, delta);
        sent++;
        @(negedge aclk);
        s_valid <= 0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (3 * NT + 8) @(negedge aclk);
    endtask

    task automatic test_directed();
        send_request(OP_QUERY, 8'd0, 0, 0, 0, 0);
        send_request(OP_QUERY, 8'd255, 0, 0, 0, 0);
        send_request(OP_SET_PERIOD, 8'd0, 16'hFFFF, 0, 0, 0);
        send_request(OP_SET_PERIOD, 8'd1, 16'd0, 0, 0, 0);
        send_request(OP_SET_PERIOD, 8'd2, 16'd2, 0, 0, 0);
        send_request(OP_SET_PERIOD, 8'd200, 16'h1234, 0, 0, 0);
        send_request(OP_SET_KIND, 8'd1, 0, KIND_DAILY, 0, 0);
        send_request(OP_SET_KIND, 8'd2, 0, KIND_MS, 0, 0);
        send_request(OP_SET_KIND, 8'd3, 0, 2'd3, 0, 0);
        send_request(OP_SET_KIND, 8'd9, 0, KIND_DAILY, 0, 0);
        send_request(OP_START, 8'd0, 0, 0, 32'hFFFF_FFF0, 0);
        send_request(OP_START, 8'd1, 0, 0, 32'd86400, 0);
        send_request(OP_START, 8'd2, 0, 0, 0, 0);
        send_request(OP_START, 8'd8, 0, 0, 0, 0);
        send_request(OP_QUERY, 8'd0, 0, 0, 0, 0);
        send_request(OP_QUERY, 8'd1, 0, 0, 0, 0);
        send_request(OP_TICK_MS, 0, 0, 0, 0, 0);
        send_request(OP_TICK_MS, 0, 0, 0, 0, 0);
        send_request(OP_TICK_MS, 0, 0, 0, 0, 0);
        send_request(OP_TICK_SEC, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_request(OP_PROCESS, 0, 0, 0, 32'd90000, 0);
        send_request(OP_SHIFT, 0, 0, 0, 0, 32'h8000_0000);
        send_request(OP_RENEW, 0, 0, 0, 32'd172799, 0);
        send_request(OP_STOP, 8'd0, 0, 0, 0, 0);
        send_request(4'd15, 8'hAA, 16'h5555, 2'd3, 32'h5555_5555, 32'h7FFF_FFFF);
        send_request(OP_QUERY, 8'd2, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic random_request();
        logic [3:0] op;
        logic [7:0] idx;
        int r;
        r = $urandom_range(0, 99);
        op = r < 15 ? OP_TICK_MS : r < 32 ? OP_TICK_SEC : r < 50 ? OP_PROCESS :
             r < 55 ? OP_RENEW : r < 63 ? OP_START : r < 67 ? OP_STOP :
             r < 73 ? OP_SET_PERIOD : r < 78 ? OP_SET_KIND : r < 82 ? OP_SHIFT :
             r < 97 ? OP_QUERY : 4'($urandom_range(10, 15));
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NT - 1));
        clock_now += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5);
        send_request(op, idx,
            $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4)),
            2'($urandom), clock_now,
            $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 10) - 5));
    endtask

    task automatic test_random_traffic();
        for (int t = 0; t < NT; t++) send_request(OP_START, t[7:0], 0, 0, clock_now, 0);
        repeat (50) random_request();
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int t = 0; t < NT; t++) begin
            send_request(OP_SET_KIND, t[7:0], 0, KIND_INTERVAL, 0, 0);
            send_request(OP_START, t[7:0], 0, 0, 32'd10, 0);
        end
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end
            repeat (4) begin
                send_request(OP_TICK_SEC, 0, 0, 0, 32'hFFFF_FFFF, 0);
                send_request(OP_PROCESS, 0, 0, 0, 32'd5, 0);
                send_request(OP_QUERY, 8'($urandom_range(0, 7)), 0, 0, 0, 0);
            end
        join
        drain_results();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        test_directed();
        test_random_traffic();
        test_backpressure();
        drain_results();
        $display("sent %0d requests; checked %0d firings and %0d query answers",
                 sent, fires_seen, queries_seen);
        if (errors == 0)
            $display("multi_channel_alarm_timer_bank_core verification clean");
        else
            $display("multi_channel_alarm_timer_bank_core verification failed");
        $finish;
    end

    initial begin
        for (int t = 0; t < NT; t++) begin
            en_q[t] = 0; rdy_q[t] = 0; kind_q[t] = KIND_INTERVAL;
            per_q[t] = 0; ms_q[t] = 0; due_q[t] = 0;
        end
    end
endmodule
